// File: rtl/core/csd_pkg.sv
package csd_pkg;

    // Stream geometry
    localparam int HEADER_BYTES    = 64;
    localparam int RECORD_BYTES    = 16;
    localparam int POS_W           = 6;
    localparam int HDR_STORE_BYTES = 52;
    localparam int REC_STORE_BYTES = 12;
    localparam int HDR_WORDS       = 11;
    localparam int HDR_IDX_W       = 4;
    localparam int HDR_FIRST_WORD  = 2;   // first emitted word sits at byte offset 8

    localparam logic [POS_W-1:0]     HDR_LAST_POS  = POS_W'(HEADER_BYTES - 1);
    localparam logic [POS_W-1:0]     REC_LAST_POS  = POS_W'(RECORD_BYTES - 1);
    localparam logic [POS_W-1:0]     HDR_STORE_END = POS_W'(HDR_STORE_BYTES);
    localparam logic [POS_W-1:0]     REC_STORE_END = POS_W'(REC_STORE_BYTES);
    localparam logic [POS_W-1:0]     MAGIC_END     = POS_W'(4);
    localparam logic [POS_W-1:0]     FORMAT_POS    = POS_W'(5);
    localparam logic [POS_W-1:0]     WORDS_START   = POS_W'(4 * HDR_FIRST_WORD);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX  = HDR_IDX_W'(HDR_WORDS - 1);

    // Job queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DROPPED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXSIZE = 2'd3;

    localparam logic [31:0] MAGIC_RESET   = 32'h4356_434D;
    localparam logic [7:0]  FORMAT_RESET  = 8'd1;
    localparam logic [31:0] DROPPED_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] MAXSIZE_RESET = 32'd8388608;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_RECORD  = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_ERROR   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_RECORD  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_MAGIC   = 3'd0,
        ERR_FORMAT  = 3'd1,
        ERR_DIM     = 3'd2,
        ERR_DROPPED = 3'd3,
        ERR_SIZE    = 3'd4
    } t_err;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  fmt;
        logic [31:0] marker;
        logic [31:0] max_bytes;
    } t_cfg;

    // One classified job; a header job expands to all header words in the back end
    typedef struct packed {
        t_kind       kind;
        t_err        err;
        logic        last;
        logic [31:0] sz;
        logic [31:0] q;
        logic [31:0] fl;
        logic [7:0]  pbyte;
    } t_job;

endpackage

// File: rtl/core/container_stream_demuxer.sv
// Results pass the job queue, then the output register. Input: one byte per cycle
// while the queue has room. Output: one result per cycle unless stalled; the
// four-entry job queue absorbs the input while the eleven header words issue.
// Reset (synchronous, active low) clears the parse state, the queue and the output
// valid, and returns the configuration registers to their defaults.
module container_stream_demuxer
    import csd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_item_kind,
    output logic [3:0]           o_field_index,
    output logic [31:0]          o_field_value,
    output logic [31:0]          o_payload_size,
    output logic signed [31:0]   o_q_index,
    output logic [31:0]          o_frame_flags,
    output logic [7:0]           o_payload_byte,
    output logic [2:0]           o_error_code,
    output logic                 o_last
);

    t_cfg                 r_cfg;
    logic                 w_push, w_pop, w_full, w_empty;
    t_job                 w_job_in, w_job_out;
    logic [HDR_IDX_W-1:0] w_hdr_rd_idx;
    logic [31:0]          w_hdr_rd_word;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic     <= MAGIC_RESET;
            r_cfg.fmt       <= FORMAT_RESET;
            r_cfg.marker    <= DROPPED_RESET;
            r_cfg.max_bytes <= MAXSIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_cfg.magic     <= i_cfg_data;
                CFG_FORMAT:  r_cfg.fmt       <= i_cfg_data[7:0];
                CFG_DROPPED: r_cfg.marker    <= i_cfg_data;
                CFG_MAXSIZE: r_cfg.max_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    csd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .o_push        (w_push),
        .o_job         (w_job_in),
        .i_fifo_full   (w_full),
        .i_hdr_rd_idx  (w_hdr_rd_idx),
        .o_hdr_rd_word (w_hdr_rd_word)
    );

    csd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_job   (w_job_out)
    );

    csd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_hdr_rd_idx   (w_hdr_rd_idx),
        .i_hdr_rd_word  (w_hdr_rd_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_item_kind    (o_item_kind),
        .o_field_index  (o_field_index),
        .o_field_value  (o_field_value),
        .o_payload_size (o_payload_size),
        .o_q_index      (o_q_index),
        .o_frame_flags  (o_frame_flags),
        .o_payload_byte (o_payload_byte),
        .o_error_code   (o_error_code),
        .o_last         (o_last)
    );

`ifndef SYNTH
    // Front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // Input stalls only for lack of queue room
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> w_full)
        else $error("input stalled with queue room");

    // The final header word, and only it, carries last
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == KIND_HEADER) |-> (o_last == (o_field_index == HDR_LAST_IDX)))
        else $error("header last flag misplaced");
`endif

endmodule

// File: rtl/core/csd_fifo.sv
module csd_fifo
    import csd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_job
);

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job;
    end

endmodule

// File: rtl/core/csd_front.sv
module csd_front
    import csd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    output logic                 o_push,
    output t_job                 o_job,
    input  logic                 i_fifo_full,
    input  logic [HDR_IDX_W-1:0] i_hdr_rd_idx,
    output logic [31:0]          o_hdr_rd_word
);

    t_phase               r_phase, n_phase;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [31:0]          r_rem, n_rem;
    logic [31:0]          r_magic_rx;
    logic [7:0]           r_fmt_rx;
    logic [31:0]          r_hdr_word [HDR_WORDS];
    logic [31:0]          r_sz, r_q, r_fl;
    logic [31:0]          w_sz, w_q, w_fl;
    logic [HDR_IDX_W-1:0] w_hdr_widx;
    logic                 w_emits;
    logic                 w_acc;
    logic                 w_magic_bad, w_fmt_bad, w_dim_bad;
    logic                 w_dropped, w_size_bad, w_last_byte;

    // Bytes that produce a job need queue room; the rest are always taken
    always_comb begin
        case (r_phase)
            PH_HEADER:  w_emits = (r_pos == HDR_LAST_POS);
            PH_RECORD:  w_emits = (r_pos == REC_LAST_POS);
            PH_PAYLOAD: w_emits = 1'b1;
            default:    w_emits = 1'b0;
        endcase
    end

    assign o_ready = !w_emits || !i_fifo_full;
    assign w_acc   = i_valid && o_ready;

    // Record words with the incoming byte merged in
    always_comb begin
        w_sz = r_sz;
        w_q  = r_q;
        w_fl = r_fl;
        if (r_phase == PH_RECORD && r_pos < REC_STORE_END) begin
            case (r_pos[3:2])
                2'd0:    w_sz[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
                2'd1:    w_q[{r_pos[1:0], 3'b000} +: 8]  = i_data_byte;
                2'd2:    w_fl[{r_pos[1:0], 3'b000} +: 8] = i_data_byte;
                default: ;
            endcase
        end
    end

    // Checks
    assign w_magic_bad = (r_magic_rx != i_cfg.magic);
    assign w_fmt_bad   = (r_fmt_rx != i_cfg.fmt);
    assign w_dim_bad   = (r_hdr_word[0] == '0) || (r_hdr_word[1] == '0);
    assign w_dropped   = (w_q == i_cfg.marker);
    assign w_size_bad  = (w_sz == '0) || (w_sz > i_cfg.max_bytes);
    assign w_last_byte = (r_rem[31:1] == '0);

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_rem   = r_rem;
        if (w_acc) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == HDR_LAST_POS) begin
                        n_pos = '0;
                        if (w_magic_bad || w_fmt_bad || w_dim_bad) n_phase = PH_ERROR;
                        else                                       n_phase = PH_RECORD;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_RECORD: begin
                    if (r_pos == REC_LAST_POS) begin
                        n_pos = '0;
                        if (w_dropped) begin
                            if (w_sz != '0) n_phase = PH_ERROR;
                        end else if (w_size_bad) begin
                            n_phase = PH_ERROR;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_rem   = w_sz;
                        end
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_rem != '0) n_rem = r_rem - 1'b1;
                    if (w_last_byte) begin
                        n_phase = PH_RECORD;
                        n_pos   = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Job output
    always_comb begin
        o_push = 1'b0;
        o_job  = '{kind: KIND_HEADER, err: ERR_MAGIC, last: 1'b0,
                   sz: '0, q: '0, fl: '0, pbyte: '0};
        if (w_acc) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == HDR_LAST_POS) begin
                        o_push = 1'b1;
                        if (w_magic_bad) begin
                            o_job.kind = KIND_ERROR;
                            o_job.err  = ERR_MAGIC;
                        end else if (w_fmt_bad) begin
                            o_job.kind = KIND_ERROR;
                            o_job.err  = ERR_FORMAT;
                        end else if (w_dim_bad) begin
                            o_job.kind = KIND_ERROR;
                            o_job.err  = ERR_DIM;
                        end
                    end
                end
                PH_RECORD: begin
                    if (r_pos == REC_LAST_POS) begin
                        o_push = 1'b1;
                        if (w_dropped) begin
                            if (w_sz != '0) begin
                                o_job.kind = KIND_ERROR;
                                o_job.err  = ERR_DROPPED;
                            end else begin
                                o_job.kind = KIND_RECORD;
                                o_job.q    = w_q;
                                o_job.fl   = w_fl;
                                o_job.last = 1'b1;
                            end
                        end else if (w_size_bad) begin
                            o_job.kind = KIND_ERROR;
                            o_job.err  = ERR_SIZE;
                        end else begin
                            o_job.kind = KIND_RECORD;
                            o_job.sz   = w_sz;
                            o_job.q    = w_q;
                            o_job.fl   = w_fl;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_push      = 1'b1;
                    o_job.kind  = KIND_PAYLOAD;
                    o_job.pbyte = i_data_byte;
                    o_job.last  = w_last_byte;
                end
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_rem   <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_rem   <= n_rem;
        end
    end

    // Header and record capture
    assign w_hdr_widx = HDR_IDX_W'(r_pos[POS_W-1:2]) - HDR_IDX_W'(HDR_FIRST_WORD);

    always_ff @(posedge i_clk) begin
        if (w_acc && r_phase == PH_HEADER) begin
            if (r_pos < MAGIC_END)
                r_magic_rx[{r_pos[1:0], 3'b000} +: 8] <= i_data_byte;
            if (r_pos == FORMAT_POS)
                r_fmt_rx <= i_data_byte;
            if (r_pos >= WORDS_START && r_pos < HDR_STORE_END)
                r_hdr_word[w_hdr_widx][{r_pos[1:0], 3'b000} +: 8] <= i_data_byte;
        end
        if (w_acc && r_phase == PH_RECORD && r_pos < REC_STORE_END) begin
            r_sz <= w_sz;
            r_q  <= w_q;
            r_fl <= w_fl;
        end
    end

    assign o_hdr_rd_word = r_hdr_word[i_hdr_rd_idx];

endmodule

// File: rtl/core/csd_back.sv
module csd_back
    import csd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_job                 i_job,
    output logic                 o_pop,
    output logic [HDR_IDX_W-1:0] o_hdr_rd_idx,
    input  logic [31:0]          i_hdr_rd_word,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_item_kind,
    output logic [3:0]           o_field_index,
    output logic [31:0]          o_field_value,
    output logic [31:0]          o_payload_size,
    output logic signed [31:0]   o_q_index,
    output logic [31:0]          o_frame_flags,
    output logic [7:0]           o_payload_byte,
    output logic [2:0]           o_error_code,
    output logic                 o_last
);

    logic                 r_valid;
    logic [HDR_IDX_W-1:0] r_cnt;
    logic                 w_issue;
    logic                 w_hdr_job;
    logic [1:0]           r_kind, n_kind;
    logic [3:0]           r_fidx, n_fidx;
    logic [31:0]          r_fval, n_fval;
    logic [31:0]          r_size, n_size;
    logic [31:0]          r_q, n_q;
    logic [31:0]          r_flags, n_flags;
    logic [7:0]           r_pbyte, n_pbyte;
    logic [2:0]           r_err, n_err;
    logic                 r_last, n_last;

    // Issue one result whenever the output slot frees up and the queue holds a job
    assign w_issue      = !i_empty && (!r_valid || i_ready);
    assign w_hdr_job    = (i_job.kind == KIND_HEADER);
    assign o_pop        = w_issue && (!w_hdr_job || r_cnt == HDR_LAST_IDX);
    assign o_hdr_rd_idx = r_cnt;

    // Result fields; fields outside the kind stay zero
    always_comb begin
        n_kind  = i_job.kind;
        n_fidx  = '0;
        n_fval  = '0;
        n_size  = '0;
        n_q     = '0;
        n_flags = '0;
        n_pbyte = '0;
        n_err   = '0;
        n_last  = 1'b0;
        case (i_job.kind)
            KIND_HEADER: begin
                n_fidx = r_cnt;
                n_fval = i_hdr_rd_word;
                n_last = (r_cnt == HDR_LAST_IDX);
            end
            KIND_RECORD: begin
                n_size  = i_job.sz;
                n_q     = i_job.q;
                n_flags = i_job.fl;
                n_last  = i_job.last;
            end
            KIND_PAYLOAD: begin
                n_pbyte = i_job.pbyte;
                n_last  = i_job.last;
            end
            default: n_err = i_job.err;
        endcase
    end

    // Header word counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (w_issue)      r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            if (w_issue && w_hdr_job)
                r_cnt <= (r_cnt == HDR_LAST_IDX) ? '0 : r_cnt + 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_kind  <= n_kind;
            r_fidx  <= n_fidx;
            r_fval  <= n_fval;
            r_size  <= n_size;
            r_q     <= n_q;
            r_flags <= n_flags;
            r_pbyte <= n_pbyte;
            r_err   <= n_err;
            r_last  <= n_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_item_kind    = r_kind;
    assign o_field_index  = r_fidx;
    assign o_field_value  = r_fval;
    assign o_payload_size = r_size;
    assign o_q_index      = $signed(r_q);
    assign o_frame_flags  = r_flags;
    assign o_payload_byte = r_pbyte;
    assign o_error_code   = r_err;
    assign o_last         = r_last;

endmodule

// File: dv/container_stream_demuxer_test.sv
module container_stream_demuxer_test;
    import csd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // How the run ends: the block stops parsing after its first format error
    typedef enum int {
        END_MAGIC,
        END_FORMAT,
        END_DIM,
        END_DROPPED,
        END_ZERO_SIZE,
        END_OVER_MAX,
        END_ZERO_LIMIT
    } t_finale;

    // One expected or observed result
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  field_idx;
        logic [31:0] word_val;
        logic [31:0] pay_size;
        logic [31:0] qidx;
        logic [31:0] flags;
        logic [7:0]  pbyte;
        logic [2:0]  err;
        logic        last;
    } t_demux_out;

    // Clock, reset and block ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [7:0]           in_byte   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           out_kind;
    logic [3:0]           out_field_index;
    logic [31:0]          out_field_value;
    logic [31:0]          out_payload_size;
    logic signed [31:0]   out_quant;
    logic [31:0]          out_frame_flags;
    logic [7:0]           out_payload_byte;
    logic [2:0]           out_error_code;
    logic                 out_last;

    // Predictor copy of the registers and the parse state
    logic [31:0]                  cfg_magic  = MAGIC_RESET;
    logic [7:0]                   cfg_format = FORMAT_RESET;
    logic [31:0]                  cfg_marker = DROPPED_RESET;
    logic [31:0]                  cfg_max    = MAXSIZE_RESET;
    t_phase                       parse_ph   = PH_HEADER;
    logic [POS_W-1:0]             parse_pos  = '0;
    logic [8*HDR_STORE_BYTES-1:0] hdr_bits   = '0;
    logic [8*REC_STORE_BYTES-1:0] rec_bits   = '0;
    logic [31:0]                  bytes_left = '0;

    logic [7:0]  stream_q[$];
    t_demux_out  expected_q[$];
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          stall_left = 0;
    int          stall_calm = 0;
    t_demux_out  seen_out;
    t_demux_out  want_out;

    container_stream_demuxer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_data_byte    (in_byte),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_item_kind    (out_kind),
        .o_field_index  (out_field_index),
        .o_field_value  (out_field_value),
        .o_payload_size (out_payload_size),
        .o_q_index      (out_quant),
        .o_frame_flags  (out_frame_flags),
        .o_payload_byte (out_payload_byte),
        .o_error_code   (out_error_code),
        .o_last         (out_last)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none, some short, few long, with calm stretches
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(16, 64);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // 32-bit value biased toward the corners
    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_demux_out blank_out(input t_kind kind);
        t_demux_out res;
        res = '0;
        res.kind = kind;
        return res;
    endfunction

    function automatic string fmt_out(input t_demux_out r);
        return $sformatf("kind=%0d idx=%0d val=%h size=%h q=%h flags=%h byte=%h err=%0d last=%0d",
                         r.kind, r.field_idx, r.word_val, r.pay_size, r.qidx, r.flags,
                         r.pbyte, r.err, r.last);
    endfunction

    task automatic flag_error(input t_err code);
        t_demux_out res;
        res = blank_out(KIND_ERROR);
        res.err = code;
        expected_q.push_back(res);
        parse_ph = PH_ERROR;
    endtask

    // Predict the results of one transferred stream byte
    task automatic demux_predict(input logic [7:0] b);
        t_demux_out  res;
        logic [31:0] sz;
        logic [31:0] q;
        logic [31:0] fl;
        int          k;
        case (parse_ph)
            PH_HEADER: begin
                if (parse_pos < HDR_STORE_END) hdr_bits[8*parse_pos +: 8] = b;
                if (parse_pos != HDR_LAST_POS) begin
                    parse_pos = parse_pos + 1'b1;
                end else begin
                    parse_pos = '0;
                    if (hdr_bits[31:0] != cfg_magic) begin
                        flag_error(ERR_MAGIC);
                    end else if (hdr_bits[47:40] != cfg_format) begin
                        flag_error(ERR_FORMAT);
                    end else if (hdr_bits[95:64] == 0 || hdr_bits[127:96] == 0) begin
                        flag_error(ERR_DIM);
                    end else begin
                        for (k = 0; k < HDR_WORDS; k++) begin
                            res = blank_out(KIND_HEADER);
                            res.field_idx = 4'(k);
                            res.word_val = hdr_bits[64 + 32*k +: 32];
                            res.last = (k == HDR_WORDS - 1);
                            expected_q.push_back(res);
                        end
                        parse_ph = PH_RECORD;
                    end
                end
            end
            PH_RECORD: begin
                if (parse_pos < REC_STORE_END) rec_bits[8*parse_pos +: 8] = b;
                if (parse_pos != REC_LAST_POS) begin
                    parse_pos = parse_pos + 1'b1;
                end else begin
                    parse_pos = '0;
                    sz = rec_bits[31:0];
                    q  = rec_bits[63:32];
                    fl = rec_bits[95:64];
                    if (q == cfg_marker) begin
                        if (sz != 0) begin
                            flag_error(ERR_DROPPED);
                        end else begin
                            res = blank_out(KIND_RECORD);
                            res.qidx = q;
                            res.flags = fl;
                            res.last = 1'b1;
                            expected_q.push_back(res);
                        end
                    end else if (sz == 0 || sz > cfg_max) begin
                        flag_error(ERR_SIZE);
                    end else begin
                        res = blank_out(KIND_RECORD);
                        res.pay_size = sz;
                        res.qidx = q;
                        res.flags = fl;
                        expected_q.push_back(res);
                        bytes_left = sz;
                        parse_ph = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                res = blank_out(KIND_PAYLOAD);
                res.pbyte = b;
                if (bytes_left > 0) bytes_left = bytes_left - 1;
                if (bytes_left == 0) begin
                    res.last = 1'b1;
                    parse_ph = PH_RECORD;
                    parse_pos = '0;
                end
                expected_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // Register write; only issued while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_MAGIC:   cfg_magic  = data;
            CFG_FORMAT:  cfg_format = data[7:0];
            CFG_DROPPED: cfg_marker = data;
            default:     cfg_max    = data;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        int i;
        for (i = 0; i < 4; i++) stream_q.push_back(w[8*i +: 8]);
    endtask

    task automatic push_noise(input int n);
        int i;
        for (i = 0; i < n; i++) stream_q.push_back(8'($urandom));
    endtask

    // Frame record: size, quantizer, flags, reserved, then payload bytes
    task automatic push_frame(input logic [31:0] sz, input logic [31:0] q,
                              input logic [31:0] fl, input int npay);
        push_word(sz);
        push_word(q);
        push_word(fl);
        push_noise(4 + npay);
    endtask

    // Header built against the current registers, broken on purpose for header finales
    task automatic push_header(input t_finale fin);
        logic [8*HEADER_BYTES-1:0] hdr;
        logic [31:0]               w;
        int                        k;
        for (k = 0; k < HEADER_BYTES; k++) hdr[8*k +: 8] = 8'($urandom);
        hdr[31:0]  = cfg_magic;
        hdr[47:40] = cfg_format;
        for (k = 0; k < HDR_WORDS; k++) begin
            w = any_word();
            if (k < 2 && w == 0) w = 32'd1;
            hdr[64 + 32*k +: 32] = w;
        end
        case (fin)
            END_MAGIC: begin
                hdr[31:0] = cfg_magic ^ (32'd1 << $urandom_range(0, 31));
                if ($urandom_range(0, 1) != 0) hdr[47:40] = ~cfg_format;
                if ($urandom_range(0, 1) != 0) hdr[95:64] = '0;
            end
            END_FORMAT: begin
                hdr[47:40] = cfg_format ^ 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1) != 0) hdr[127:96] = '0;
            end
            END_DIM: begin
                case ($urandom_range(0, 2))
                    0: hdr[95:64] = '0;
                    1: hdr[127:96] = '0;
                    default: hdr[127:64] = '0;
                endcase
            end
            default: ;
        endcase
        for (k = 0; k < HEADER_BYTES; k++) stream_q.push_back(hdr[8*k +: 8]);
    endtask

    // Wait until every byte is transferred and every result has arrived
    task automatic wait_idle();
        while (stream_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Byte driver with random gaps between transfers
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) demux_predict(in_byte);
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (stream_q.size() != 0) begin
                    in_byte  <= stream_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap = idle_len(send_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                seen_out = '{kind: t_kind'(out_kind), field_idx: out_field_index,
                             word_val: out_field_value, pay_size: out_payload_size,
                             qidx: out_quant, flags: out_frame_flags,
                             pbyte: out_payload_byte, err: out_error_code,
                             last: out_last};
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, got %s",
                             $time, fmt_out(seen_out));
                end else begin
                    want_out = expected_q.pop_front();
                    if (seen_out !== want_out) begin
                        mismatch_count++;
                        $display("%0t: mismatch, expected %s, got %s",
                                 $time, fmt_out(want_out), fmt_out(seen_out));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                stall_left = idle_len(stall_calm);
            end
        end
    end

    // Stimulus: header, then noise after a broken header, or directed records, one random phase and one broken item
    initial begin
        t_finale     fin;
        int          r;
        int          n_rec;
        int          cap;
        logic [31:0] sz;
        logic [31:0] q;
        logic [31:0] hi;

        case ($urandom_range(0, 9))
            0: fin = END_MAGIC;
            1: fin = END_FORMAT;
            2: fin = END_DIM;
            3, 4: fin = END_DROPPED;
            5: fin = END_ZERO_SIZE;
            6, 7: fin = END_OVER_MAX;
            default: fin = END_ZERO_LIMIT;
        endcase

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first settings
        case ($urandom_range(0, 3))
            0: cfg_write(CFG_MAGIC, MAGIC_RESET);
            1: cfg_write(CFG_MAGIC, 32'h0000_0000);
            2: cfg_write(CFG_MAGIC, 32'hFFFF_FFFF);
            default: cfg_write(CFG_MAGIC, $urandom);
        endcase
        case ($urandom_range(0, 3))
            0: cfg_write(CFG_FORMAT, 32'd0);
            1: cfg_write(CFG_FORMAT, 32'd255);
            2: cfg_write(CFG_FORMAT, 32'(FORMAT_RESET));
            default: cfg_write(CFG_FORMAT, $urandom);
        endcase
        cfg_write(CFG_DROPPED, any_word());
        cfg_write(CFG_MAXSIZE, 32'd1);

        push_header(fin);
        if (fin == END_MAGIC || fin == END_FORMAT || fin == END_DIM) begin
            // header rejected: everything after it is dropped
            push_noise(36);
        end else begin
            // dropped frame, then a frame exactly at the size limit
            push_frame(32'd0, cfg_marker, 32'hFFFF_FFFF, 0);
            q = (cfg_marker == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'h8000_0000;
            push_frame(32'd1, q, 32'd0, 1);
            wait_idle();

            // random phase under its own marker and limit
            if ($urandom_range(0, 2) == 0) begin
                cfg_write(CFG_MAGIC, $urandom);
                cfg_write(CFG_FORMAT, $urandom);
            end
            cfg_write(CFG_DROPPED, any_word());
            case ($urandom_range(0, 4))
                0: cfg_write(CFG_MAXSIZE, 32'd1);
                1: cfg_write(CFG_MAXSIZE, 32'($urandom_range(2, 8)));
                2: cfg_write(CFG_MAXSIZE, 32'hFFFF_FFFF);
                3: cfg_write(CFG_MAXSIZE, MAXSIZE_RESET);
                default: cfg_write(CFG_MAXSIZE, $urandom | 32'd1);
            endcase
            n_rec = $urandom_range(1, 2);
            for (r = 0; r < n_rec; r++) begin
                if ($urandom_range(0, 4) == 0) begin
                    push_frame(32'd0, cfg_marker, any_word(), 0);
                end else begin
                    q = any_word();
                    if (q == cfg_marker) q = ~q;
                    cap = ($urandom_range(0, 7) == 0) ? 64 : 10;
                    hi = (cfg_max < 32'(cap)) ? cfg_max : 32'(cap);
                    if (r == n_rec - 1 && cfg_max <= 64) sz = cfg_max;
                    else sz = $urandom_range(1, hi);
                    push_frame(sz, q, any_word(), int'(sz));
                end
            end
            wait_idle();

            // one broken record, then bytes that must be dropped
            q = any_word();
            if (q == cfg_marker) q = ~q;
            case (fin)
                END_DROPPED: begin
                    sz = any_word();
                    if (sz == 0) sz = 32'd1;
                    push_frame(sz, cfg_marker, any_word(), 0);
                end
                END_ZERO_SIZE: push_frame(32'd0, q, any_word(), 0);
                END_OVER_MAX: begin
                    if ($urandom_range(0, 1) != 0) cfg_write(CFG_MAXSIZE, 32'hFFFF_FFFE);
                    else cfg_write(CFG_MAXSIZE, 32'($urandom_range(1, 50)));
                    push_frame(cfg_max + 1, q, any_word(), 0);
                end
                default: begin
                    cfg_write(CFG_MAXSIZE, 32'd0);
                    push_frame(any_word(), q, any_word(), 0);
                end
            endcase
            push_noise(8);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop for a hung run
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
